// File: src/timed_priority_task_queue_macros.svh
// assertion macros for the timed priority task queue
// used by the top level only, no other dependencies
`ifndef TIMED_PRIORITY_TASK_QUEUE_MACROS_SVH
`define TIMED_PRIORITY_TASK_QUEUE_MACROS_SVH

// same-cycle implication under reset
`define TPTQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tptq check failed");

// next-cycle implication under reset
`define TPTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tptq check failed");

`endif

// File: src/tptq_pkg.sv
// shared types, codes and helpers of the timed priority task queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tptq_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_BITS = $clog2(MAX_TASKS);
    localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);
    localparam int ID_BITS   = 16;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_REMOVED   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_REFUSED   = 3'd3;
    localparam logic [2:0] ST_DISPATCH  = 3'd4;
    localparam logic [2:0] ST_NONE_DUE  = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] due_time;
        logic [7:0]  prio;
        logic [31:0] handle;
        logic [15:0] target_id;
        logic [31:0] now_tick;
        logic        drain;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] task_ident;
        logic [31:0] task_handle;
        logic [6:0]  run_count;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [ID_BITS-1:0] ident;
        logic [31:0]        due;
        logic [7:0]         prio;
        logic [31:0]        handle;
    } t_slot;

    // wrap-aware a later than b
    function automatic logic tick_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage

`default_nettype wire

// File: src/tptq_ifs.sv
// valid/ready channel interfaces for task items and result words
// depends on tptq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tptq_in_if;
    logic         valid;
    logic         ready;
    tptq_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tptq_out_if;
    logic          valid;
    logic          ready;
    tptq_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/timed_priority_task_queue.sv
// top level: sequencer over the slot table ram and the time-order list ram
// depends on tptq_pkg, tptq_ifs, tptq_ram and the assertion macro header
//
//  channel   dir  word   accepted when
//  i_task    in   t_in   i_task.valid && i_task.ready
//  o_res     out  t_out  o_res.valid && o_res.ready
//
// one item at a time; each list entry scanned takes a list read, a slot read
// and a compare, and each entry moved takes a read and a write back
// add: a scan of the entries before the insert point, then a shift of each entry after it
// run: one scan and one unlink per dispatched task, results held in one register
// reset is synchronous and empties the table; a stalled result word holds the sequencer
`timescale 1ns / 1ps
`default_nettype none
`include "timed_priority_task_queue_macros.svh"

module timed_priority_task_queue (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tptq_in_if.sink     i_task,
    tptq_out_if.source  o_res
);

    localparam int SB = tptq_pkg::SLOT_BITS;
    localparam int CB = tptq_pkg::CNT_BITS;
    localparam int SW = $bits(tptq_pkg::t_slot);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ADD     = 4'd1;
    localparam logic [3:0] S_ORD_RD  = 4'd2;
    localparam logic [3:0] S_ORD_WT  = 4'd3;
    localparam logic [3:0] S_SLOT_WT = 4'd4;
    localparam logic [3:0] S_SH_RD   = 4'd5;
    localparam logic [3:0] S_SH_WR   = 4'd6;
    localparam logic [3:0] S_INS     = 4'd7;
    localparam logic [3:0] S_DEL_RD  = 4'd8;
    localparam logic [3:0] S_DEL_WR  = 4'd9;
    localparam logic [3:0] S_PICKED  = 4'd10;
    localparam logic [3:0] S_UNLINK  = 4'd11;
    localparam logic [3:0] S_EMIT    = 4'd12;

    logic [3:0]                  r_state;
    logic [3:0]                  r_ret;
    logic [tptq_pkg::MAX_TASKS-1:0] r_valid;
    logic [CB-1:0]               r_cnt;
    logic [tptq_pkg::ID_BITS-1:0] r_next_id;
    tptq_pkg::t_in               r_req;
    logic [CB-1:0]               r_i;
    logic [CB-1:0]               r_j;
    logic [CB-1:0]               r_pos;
    logic [SB-1:0]               r_slot;
    logic [SB-1:0]               r_cur;
    logic                        r_found;
    logic [CB-1:0]               r_bpos;
    logic [SB-1:0]               r_bslot;
    logic [7:0]                  r_bprio;
    logic [15:0]                 r_bid;
    logic [31:0]                 r_bh;
    logic                        r_pend;
    logic [15:0]                 r_pid;
    logic [31:0]                 r_ph;
    logic [6:0]                  r_n;
    tptq_pkg::t_out              r_stg;
    tptq_pkg::t_out              r_out;
    logic                        r_ovalid;

    logic                        free_ok;
    logic [SB-1:0]               free_idx;
    logic                        add_ok;
    logic [CB-1:0]               j_dec;
    logic [CB-1:0]               j_inc;
    logic [CB-1:0]               i_inc;
    logic                        ord_we;
    logic [SB-1:0]               ord_waddr;
    logic [SB-1:0]               ord_wdata;
    logic [SB-1:0]               ord_raddr;
    logic [SB-1:0]               ord_rdata;
    logic                        slot_we;
    tptq_pkg::t_slot             slot_wdata;
    logic [SW-1:0]               slot_rraw;
    tptq_pkg::t_slot             slot_rdata;
    logic                        out_free;

    assign j_dec      = r_j - CB'(1);
    assign j_inc      = r_j + CB'(1);
    assign i_inc      = r_i + CB'(1);
    assign add_ok     = free_ok && (r_req.handle != 32'd0);
    assign out_free   = !r_ovalid || o_res.ready;
    assign slot_rdata = tptq_pkg::t_slot'(slot_rraw);

    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int k = tptq_pkg::MAX_TASKS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_ok  = 1'b1;
                free_idx = SB'(k);
            end
        end
    end

    always_comb begin
        ord_raddr = r_i[SB-1:0];
        ord_we    = 1'b0;
        ord_waddr = r_j[SB-1:0];
        ord_wdata = ord_rdata;
        unique case (r_state) inside
            S_SH_RD:  ord_raddr = j_dec[SB-1:0];
            S_DEL_RD: ord_raddr = j_inc[SB-1:0];
            S_SH_WR,
            S_DEL_WR: ord_we = 1'b1;
            S_INS: begin
                ord_we    = 1'b1;
                ord_waddr = r_pos[SB-1:0];
                ord_wdata = r_slot;
            end
            default: ;
        endcase
    end

    assign slot_we    = (r_state == S_ADD) && add_ok;
    assign slot_wdata = '{ident: r_next_id, due: r_req.due_time,
                          prio: r_req.prio, handle: r_req.handle};

    tptq_ram #(.WIDTH(SB), .DEPTH(tptq_pkg::MAX_TASKS)) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    tptq_ram #(.WIDTH(SW), .DEPTH(tptq_pkg::MAX_TASKS)) u_slots (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (free_idx),
        .i_wdata (slot_wdata),
        .i_raddr (ord_rdata),
        .o_rdata (slot_rraw)
    );

    assign i_task.ready = (r_state == S_IDLE);
    assign o_res.valid  = r_ovalid;
    assign o_res.data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_cnt     <= '0;
            r_next_id <= '0;
            r_ovalid  <= 1'b0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            if (o_res.ready && !((r_state == S_EMIT) && out_free)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_task.valid) begin
                        r_req   <= i_task.data;
                        r_i     <= '0;
                        r_found <= 1'b0;
                        r_pend  <= 1'b0;
                        r_n     <= '0;
                        case (i_task.data.kind) inside
                            tptq_pkg::KIND_ADD:    r_state <= S_ADD;
                            tptq_pkg::KIND_REMOVE,
                            tptq_pkg::KIND_RUN:    r_state <= S_ORD_RD;
                            default:               r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ADD: begin
                    if (add_ok) begin
                        r_valid[free_idx] <= 1'b1;
                        r_slot            <= free_idx;
                        r_state           <= S_ORD_RD;
                    end else begin
                        r_stg   <= '{status: tptq_pkg::ST_REFUSED, task_ident: '0,
                                     task_handle: '0, run_count: '0, last: 1'b1};
                        r_ret   <= S_IDLE;
                        r_state <= S_EMIT;
                    end
                end
                S_ORD_RD: begin
                    if (r_i == r_cnt) begin
                        case (r_req.kind)
                            tptq_pkg::KIND_ADD: begin
                                r_pos   <= r_cnt;
                                r_j     <= r_cnt;
                                r_state <= S_SH_RD;
                            end
                            tptq_pkg::KIND_REMOVE: begin
                                r_stg   <= '{status: tptq_pkg::ST_NOT_FOUND, task_ident: '0,
                                             task_handle: '0, run_count: '0, last: 1'b1};
                                r_ret   <= S_IDLE;
                                r_state <= S_EMIT;
                            end
                            default: r_state <= S_PICKED;
                        endcase
                    end else begin
                        r_state <= S_ORD_WT;
                    end
                end
                S_ORD_WT: begin
                    r_cur   <= ord_rdata;
                    r_state <= S_SLOT_WT;
                end
                S_SLOT_WT: begin
                    r_i     <= i_inc;
                    r_state <= S_ORD_RD;
                    case (r_req.kind)
                        tptq_pkg::KIND_ADD: begin
                            if (tptq_pkg::tick_after(slot_rdata.due, r_req.due_time)) begin
                                r_pos   <= r_i;
                                r_j     <= r_cnt;
                                r_state <= S_SH_RD;
                            end
                        end
                        tptq_pkg::KIND_REMOVE: begin
                            if (slot_rdata.ident == r_req.target_id) begin
                                r_valid[r_cur] <= 1'b0;
                                r_j            <= r_i;
                                r_state        <= S_DEL_RD;
                            end
                        end
                        default: begin
                            if (tptq_pkg::tick_after(slot_rdata.due, r_req.now_tick)) begin
                                r_state <= S_PICKED;
                            end else if (!r_found || (slot_rdata.prio > r_bprio)) begin
                                r_found <= 1'b1;
                                r_bpos  <= r_i;
                                r_bslot <= r_cur;
                                r_bprio <= slot_rdata.prio;
                                r_bid   <= 16'(slot_rdata.ident);
                                r_bh    <= slot_rdata.handle;
                            end
                        end
                    endcase
                end
                S_SH_RD: begin
                    r_state <= (r_j == r_pos) ? S_INS : S_SH_WR;
                end
                S_SH_WR: begin
                    r_j     <= j_dec;
                    r_state <= S_SH_RD;
                end
                S_INS: begin
                    r_cnt     <= r_cnt + CB'(1);
                    r_next_id <= r_next_id + tptq_pkg::ID_BITS'(1);
                    r_stg     <= '{status: tptq_pkg::ST_ADDED, task_ident: 16'(r_next_id),
                                   task_handle: '0, run_count: '0, last: 1'b1};
                    r_ret     <= S_IDLE;
                    r_state   <= S_EMIT;
                end
                S_DEL_RD: begin
                    if (j_inc >= r_cnt) begin
                        r_cnt <= r_cnt - CB'(1);
                        r_ret <= S_IDLE;
                        if (r_req.kind == tptq_pkg::KIND_REMOVE) begin
                            r_stg   <= '{status: tptq_pkg::ST_REMOVED, task_ident: '0,
                                         task_handle: '0, run_count: '0, last: 1'b1};
                            r_state <= S_EMIT;
                        end else if (r_req.drain) begin
                            r_pend  <= 1'b1;
                            r_found <= 1'b0;
                            r_i     <= '0;
                            r_state <= S_ORD_RD;
                        end else begin
                            r_stg   <= '{status: tptq_pkg::ST_DISPATCH, task_ident: r_pid,
                                         task_handle: r_ph, run_count: r_n, last: 1'b1};
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_state <= S_DEL_WR;
                    end
                end
                S_DEL_WR: begin
                    r_j     <= j_inc;
                    r_state <= S_DEL_RD;
                end
                S_PICKED: begin
                    if (r_pend) begin
                        r_stg   <= '{status: tptq_pkg::ST_DISPATCH, task_ident: r_pid,
                                     task_handle: r_ph, run_count: r_n, last: !r_found};
                        r_ret   <= r_found ? S_UNLINK : S_IDLE;
                        r_state <= S_EMIT;
                    end else if (!r_found) begin
                        r_stg   <= '{status: tptq_pkg::ST_NONE_DUE, task_ident: '0,
                                     task_handle: '0, run_count: '0, last: 1'b1};
                        r_ret   <= S_IDLE;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_UNLINK;
                    end
                end
                S_UNLINK: begin
                    r_pid            <= r_bid;
                    r_ph             <= r_bh;
                    r_n              <= r_n + 7'd1;
                    r_valid[r_bslot] <= 1'b0;
                    r_j              <= r_bpos;
                    r_state          <= S_DEL_RD;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out    <= r_stg;
                        r_ovalid <= 1'b1;
                        r_state  <= r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TPTQ_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CB'(tptq_pkg::MAX_TASKS))
    `TPTQ_ASSERT_NOW(a_cnt_valid, i_clk, i_rst_n, r_state == S_IDLE, r_cnt == CB'($countones(r_valid)))
    `TPTQ_ASSERT_NOW(a_dispatch_count, i_clk, i_rst_n, r_ovalid && (r_out.status == tptq_pkg::ST_DISPATCH), r_out.run_count != 7'd0)

endmodule

`default_nettype wire

// File: src/tptq_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tptq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
